// ----- rtl/pee_pkg.sv -----
// Package with shared types, constants and codes of the postfix evaluator.
`default_nettype none
package pee_pkg;

  localparam int unsigned STACK_DEPTH = 128;
  localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_PLUS = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_TIMES = 8'h2a;
  localparam logic [7:0] CHAR_DIVIDE = 8'h2f;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_DIGIT,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_DROP
  } op_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } out_word_t;

  // Classified word passed from the front to the back.
  typedef struct packed {
    op_t        op;
    logic [3:0] digit;
    logic       last;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP1_RD,
    S_POP1_WT,
    S_POP2_RD,
    S_POP2_WT,
    S_EXEC,
    S_DIV,
    S_MUL,
    S_PUSH,
    S_FIN_RD,
    S_FIN_WT,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/postfix_expression_evaluator_core.sv -----
// Postfix evaluator: one character per word, result word on the final character.
// A word waits in the command queue; the back part then pushes a digit, or pops two
// operands for an add, subtract, multiply, divide or discard and pushes the result,
// save for a discard; a divide runs the iterative divider. The final character adds
// a stack read before its result word shows. A two-entry command queue lets input
// words arrive while the back part works. Synchronous reset empties the stack,
// clears the error and the command queue, but not the result register; no sweep.
`default_nettype none
module postfix_expression_evaluator_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pee_pkg::in_word_t  in_word,
  input  wire logic               push,
  output logic                    full,
  output pee_pkg::out_word_t      out_word,
  output logic                    empty,
  input  wire logic               pop
);
  pee_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_take;

  pee_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .push      (push),
    .full      (full),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take)
  );

  pee_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .out_word  (out_word),
    .empty     (empty),
    .pop       (pop)
  );

  // A result word stays put until it is popped.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_word))
    else $error("result word changed before pop");

  // The back part takes no command while a result waits.
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !cmd_take)
    else $error("command taken while result pending");
endmodule
`default_nettype wire

// ----- rtl/pee_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none
module pee_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                  wdata,
  output logic      [WIDTH-1:0]                  rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read share one address; read data is registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- rtl/pee_front.sv -----
// Front part: accepts characters, classifies them and queues the commands.
`default_nettype none
module pee_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pee_pkg::in_word_t in_word,
  input  wire logic             push,
  output logic                  full,
  output pee_pkg::cmd_t         cmd,
  output logic                  cmd_valid,
  input  wire logic             cmd_take
);
  localparam int unsigned QA = $clog2(pee_pkg::QUEUE_DEPTH);
  pee_pkg::cmd_t   q [pee_pkg::QUEUE_DEPTH];
  logic [QA-1:0]   wr_ptr;
  logic [QA-1:0]   rd_ptr;
  logic [QA:0]     count;
  pee_pkg::cmd_t   cls;
  logic            do_wr;
  logic            do_rd;

  // Decode the character into an operation.
  always_comb begin
    cls.last = in_word.last;
    cls.digit = in_word.symbol[3:0] - pee_pkg::CHAR_ZERO[3:0];
    if (in_word.symbol >= pee_pkg::CHAR_ZERO && in_word.symbol <= pee_pkg::CHAR_NINE) begin
      cls.op = pee_pkg::OP_DIGIT;
    end else begin
      unique case (in_word.symbol)
        pee_pkg::CHAR_PLUS:   cls.op = pee_pkg::OP_ADD;
        pee_pkg::CHAR_MINUS:  cls.op = pee_pkg::OP_SUB;
        pee_pkg::CHAR_TIMES:  cls.op = pee_pkg::OP_MUL;
        pee_pkg::CHAR_DIVIDE: cls.op = pee_pkg::OP_DIV;
        default:              cls.op = pee_pkg::OP_DROP;
      endcase
    end
  end

  assign full = (count == (QA+1)'(pee_pkg::QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd = q[rd_ptr];
  assign do_wr = push && !full;
  assign do_rd = cmd_take && cmd_valid;

  // Command queue storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      q[wr_ptr] <= cls;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (!do_wr && do_rd) count <= count - 1'b1;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/pee_divider.sv -----
// Iterative restoring divider for signed 32-bit operands, truncating toward zero.
`default_nettype none
module pee_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] mag_d;
  logic        neg;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, mag_d};
  assign quotient = neg ? (32'd0 - quo) : quo;

  // One quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend[31] ? (32'd0 - dividend) : dividend;
      mag_d <= divisor[31] ? (32'd0 - divisor) : divisor;
      neg <= dividend[31] ^ divisor[31];
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/pee_back.sv -----
// Back part: runs the operand stack, the arithmetic and the result register.
`default_nettype none
module pee_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pee_pkg::cmd_t     cmd,
  input  wire logic              cmd_valid,
  output logic                   cmd_take,
  output pee_pkg::out_word_t     out_word,
  output logic                   empty,
  input  wire logic              pop
);
  localparam int unsigned AW = pee_pkg::ADDR_W;
  localparam int unsigned SW = pee_pkg::SP_W;

  pee_pkg::state_t state, state_next;
  pee_pkg::cmd_t   cur;
  logic [SW-1:0]   sp;
  logic [1:0]      err;
  logic [31:0]     n1;
  logic [31:0]     n2;
  logic [31:0]     res;
  logic [31:0]     prod;
  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  logic [31:0]     ram_wdata;
  logic [31:0]     ram_rdata;
  logic            div_start;
  logic            div_done;
  logic [31:0]     div_q;
  logic            sp_empty;
  logic            sp_full;

  assign sp_empty = (sp == '0);
  assign sp_full = (sp == SW'(pee_pkg::STACK_DEPTH));

  pee_ram #(.WIDTH(32), .DEPTH(pee_pkg::STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  pee_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (n2),
    .divisor  (n1),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sequencer next state and strobes.
  always_comb begin
    state_next = state;
    cmd_take = 1'b0;
    ram_we = 1'b0;
    ram_addr = AW'(sp - 1'b1);
    ram_wdata = res;
    div_start = 1'b0;
    unique case (state)
      pee_pkg::S_IDLE: begin
        if (cmd_valid) begin
          cmd_take = 1'b1;
          if (cmd.op == pee_pkg::OP_DIGIT) state_next = pee_pkg::S_PUSH;
          else state_next = pee_pkg::S_POP1_RD;
        end
      end
      pee_pkg::S_POP1_RD: state_next = pee_pkg::S_POP1_WT;
      pee_pkg::S_POP1_WT: state_next = pee_pkg::S_POP2_RD;
      pee_pkg::S_POP2_RD: state_next = pee_pkg::S_POP2_WT;
      pee_pkg::S_POP2_WT: state_next = pee_pkg::S_EXEC;
      pee_pkg::S_EXEC: begin
        unique case (cur.op)
          pee_pkg::OP_MUL: state_next = pee_pkg::S_MUL;
          pee_pkg::OP_DIV: begin
            if (n1 == '0) begin
              state_next = pee_pkg::S_PUSH;
            end else begin
              div_start = 1'b1;
              state_next = pee_pkg::S_DIV;
            end
          end
          pee_pkg::OP_DROP: state_next = cur.last ? pee_pkg::S_FIN_RD : pee_pkg::S_IDLE;
          default: state_next = pee_pkg::S_PUSH;
        endcase
      end
      pee_pkg::S_MUL: state_next = pee_pkg::S_PUSH;
      pee_pkg::S_DIV: if (div_done) state_next = pee_pkg::S_PUSH;
      pee_pkg::S_PUSH: begin
        ram_addr = AW'(sp);
        ram_we = !sp_full;
        state_next = cur.last ? pee_pkg::S_FIN_RD : pee_pkg::S_IDLE;
      end
      pee_pkg::S_FIN_RD: state_next = pee_pkg::S_FIN_WT;
      pee_pkg::S_FIN_WT: state_next = pee_pkg::S_OUT;
      pee_pkg::S_OUT: if (pop) state_next = pee_pkg::S_IDLE;
      default: state_next = pee_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= pee_pkg::S_IDLE;
    else state <= state_next;
  end

  assign empty = (state != pee_pkg::S_OUT);
  assign prod = n2 * n1;

  // Stack pointer and sticky error.
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
      err <= pee_pkg::ST_OK;
    end else begin
      unique case (state)
        pee_pkg::S_POP1_RD, pee_pkg::S_POP2_RD, pee_pkg::S_FIN_RD: begin
          if (sp_empty) begin
            if (err == pee_pkg::ST_OK) err <= pee_pkg::ST_UNDER;
          end else begin
            sp <= sp - 1'b1;
          end
        end
        pee_pkg::S_EXEC: begin
          if (cur.op == pee_pkg::OP_DIV && n1 == '0 && err == pee_pkg::ST_OK) begin
            err <= pee_pkg::ST_DIVZ;
          end
        end
        pee_pkg::S_PUSH: begin
          if (sp_full) begin
            if (err == pee_pkg::ST_OK) err <= pee_pkg::ST_OVER;
          end else begin
            sp <= sp + 1'b1;
          end
        end
        pee_pkg::S_OUT: begin
          if (pop) begin
            sp <= '0;
            err <= pee_pkg::ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

  // Operand capture, result computation and output word.
  logic pop_hit;
  always_ff @(posedge clk) begin
    if (state == pee_pkg::S_IDLE && cmd_valid) begin
      cur <= cmd;
      res <= {28'd0, cmd.digit};
    end
    if (state == pee_pkg::S_POP1_RD || state == pee_pkg::S_POP2_RD ||
        state == pee_pkg::S_FIN_RD) begin
      pop_hit <= !sp_empty;
    end
    if (state == pee_pkg::S_POP1_WT) n1 <= pop_hit ? ram_rdata : '0;
    if (state == pee_pkg::S_POP2_WT) n2 <= pop_hit ? ram_rdata : '0;
    if (state == pee_pkg::S_EXEC) begin
      case (cur.op)
        pee_pkg::OP_ADD: res <= n2 + n1;
        pee_pkg::OP_SUB: res <= n2 - n1;
        default:         res <= '0;
      endcase
    end
    if (state == pee_pkg::S_MUL) res <= prod;
    if (state == pee_pkg::S_DIV && div_done) res <= div_q;
    if (state == pee_pkg::S_FIN_WT) begin
      out_word.value <= pop_hit ? ram_rdata : '0;
      out_word.status <= err;
    end
  end
endmodule
`default_nettype wire
